@@ hdl/snfc_pkg.sv @@
// ----------------------------------------------------------------------------
// snfc_pkg
// Types, codes and constants shared by the SPI NOR command sequencer modules.
// ----------------------------------------------------------------------------
package snfc_pkg;

   // Default parameter values
   localparam int DEF_PAGE_BYTES   = 256;
   localparam int DEF_ADDRESS_BITS = 24;

   // Fixed field widths
   localparam int ADDR_FIELD_BITS = 24;
   localparam int LEN_FIELD_BITS  = 24;

   // Longest action list caused by one item, and its count width
   localparam int MAX_STEPS  = 9;
   localparam int STEP_BITS  = $clog2(MAX_STEPS);
   localparam int COUNT_BITS = $clog2(MAX_STEPS + 1);

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Request opcodes
   localparam logic [2:0] OP_START_READ  = 3'd0;
   localparam logic [2:0] OP_ERASE       = 3'd1;
   localparam logic [2:0] OP_START_WRITE = 3'd2;
   localparam logic [2:0] OP_WRITE_DATA  = 3'd3;
   localparam logic [2:0] OP_SPI_RX      = 3'd4;

   // Result actions
   localparam logic [2:0] ACT_SEND = 3'd0;
   localparam logic [2:0] ACT_RECV = 3'd1;
   localparam logic [2:0] ACT_REL  = 3'd2;
   localparam logic [2:0] ACT_DATA = 3'd3;
   localparam logic [2:0] ACT_DONE = 3'd4;
   localparam logic [2:0] ACT_REJ  = 3'd5;

   // Flash command bytes
   localparam logic [7:0] CMD_WREN  = 8'h06;
   localparam logic [7:0] CMD_PROG  = 8'h02;
   localparam logic [7:0] CMD_READ  = 8'h03;
   localparam logic [7:0] CMD_ERASE = 8'h20;
   localparam logic [7:0] CMD_RDSR  = 8'h05;

   // Sequencer phase
   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_READ  = 4'd1,
      PH_WDATA = 4'd2,
      PH_POLL  = 4'd3
   } phase_type;

   // Operation in progress
   typedef enum logic [1:0] {
      PEND_NONE  = 2'd0,
      PEND_READ  = 2'd1,
      PEND_ERASE = 2'd2,
      PEND_WRITE = 2'd3
   } pend_type;

   typedef struct packed {
      logic [2:0]                 opcode;
      logic [ADDR_FIELD_BITS-1:0] address;
      logic [LEN_FIELD_BITS-1:0]  length;
      logic [7:0]                 data;
   } req_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] byte_value;
      logic       last;
   } rsp_type;

   // One SPI action of a job
   typedef struct packed {
      logic [2:0] action;
      logic [7:0] byte_value;
   } step_type;

   // Ordered action list for one item; steps[0] goes out first
   typedef struct packed {
      logic [COUNT_BITS-1:0]         count;
      step_type [MAX_STEPS-1:0]      steps;
   } job_type;

   function automatic step_type mk_step(logic [2:0] act, logic [7:0] value);
      step_type s;
      s.action     = act;
      s.byte_value = value;
      return s;
   endfunction

endpackage

@@ hdl/snfc_front.sv @@
// ----------------------------------------------------------------------------
// snfc_front
// Accepts items, checks them against the sequencer phase, updates the
// operation state and builds the action list for each item.
// ----------------------------------------------------------------------------
module snfc_front #(
   parameter int PAGE_BYTES   = snfc_pkg::DEF_PAGE_BYTES,
   parameter int ADDRESS_BITS = snfc_pkg::DEF_ADDRESS_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  snfc_pkg::req_type req_payload,
   input  logic              q_full,
   output logic              q_push,
   output snfc_pkg::job_type q_job
);
   import snfc_pkg::*;

   localparam int PAGE_BITS = $clog2(PAGE_BYTES);

   phase_type                 phase_ff, phase_in;
   pend_type                  pend_ff, pend_in;
   logic [ADDRESS_BITS-1:0]   addr_ff, addr_in;
   logic [LEN_FIELD_BITS-1:0] remain_ff, remain_in;

   logic                       accept;
   logic [ADDRESS_BITS-1:0]    req_addr;
   logic [ADDR_FIELD_BITS-1:0] req_a24;
   logic [ADDR_FIELD_BITS-1:0] cur_a24;
   logic [ADDRESS_BITS-1:0]    addr_inc;
   logic [LEN_FIELD_BITS-1:0]  remain_dec;
   logic                       len_zero;
   logic                       chunk_end;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign q_push    = accept;

   assign req_addr   = req_payload.address[ADDRESS_BITS-1:0];
   assign req_a24    = ADDR_FIELD_BITS'(req_addr);
   assign cur_a24    = ADDR_FIELD_BITS'(addr_ff);
   assign addr_inc   = addr_ff + 1'b1;
   assign remain_dec = remain_ff - 1'b1;
   assign len_zero   = (req_payload.length == '0);
   assign chunk_end  = (remain_dec == '0) || (addr_inc[PAGE_BITS-1:0] == '0);

   // Classify the item and build its action list
   always_comb begin
      phase_in  = phase_ff;
      pend_in   = pend_ff;
      addr_in   = addr_ff;
      remain_in = remain_ff;
      q_job          = '0;
      q_job.count    = COUNT_BITS'(1);
      q_job.steps[0] = mk_step(ACT_REJ, 8'h00);

      unique case (req_payload.opcode)
         OP_START_READ: begin
            if (phase_ff == PH_IDLE) begin
               addr_in   = req_addr;
               remain_in = req_payload.length;
               q_job.steps[0] = mk_step(ACT_SEND, CMD_READ);
               q_job.steps[1] = mk_step(ACT_SEND, req_a24[23:16]);
               q_job.steps[2] = mk_step(ACT_SEND, req_a24[15:8]);
               q_job.steps[3] = mk_step(ACT_SEND, req_a24[7:0]);
               if (len_zero) begin
                  q_job.steps[4] = mk_step(ACT_REL, 8'h00);
                  q_job.steps[5] = mk_step(ACT_DONE, 8'h00);
                  q_job.count    = COUNT_BITS'(6);
                  phase_in = PH_IDLE;
                  pend_in  = PEND_NONE;
               end else begin
                  q_job.steps[4] = mk_step(ACT_RECV, 8'h00);
                  q_job.count    = COUNT_BITS'(5);
                  phase_in = PH_READ;
                  pend_in  = PEND_READ;
               end
            end
         end
         OP_ERASE: begin
            if (phase_ff == PH_IDLE) begin
               addr_in   = req_addr;
               remain_in = '0;
               q_job.steps[0] = mk_step(ACT_SEND, CMD_WREN);
               q_job.steps[1] = mk_step(ACT_REL, 8'h00);
               q_job.steps[2] = mk_step(ACT_SEND, CMD_ERASE);
               q_job.steps[3] = mk_step(ACT_SEND, req_a24[23:16]);
               q_job.steps[4] = mk_step(ACT_SEND, req_a24[15:8]);
               q_job.steps[5] = mk_step(ACT_SEND, req_a24[7:0]);
               q_job.steps[6] = mk_step(ACT_REL, 8'h00);
               q_job.steps[7] = mk_step(ACT_SEND, CMD_RDSR);
               q_job.steps[8] = mk_step(ACT_RECV, 8'h00);
               q_job.count    = COUNT_BITS'(9);
               phase_in = PH_POLL;
               pend_in  = PEND_ERASE;
            end
         end
         OP_START_WRITE: begin
            if (phase_ff == PH_IDLE) begin
               addr_in   = req_addr;
               remain_in = req_payload.length;
               if (len_zero) begin
                  q_job.steps[0] = mk_step(ACT_DONE, 8'h00);
                  q_job.count    = COUNT_BITS'(1);
                  phase_in = PH_IDLE;
                  pend_in  = PEND_NONE;
               end else begin
                  q_job.steps[0] = mk_step(ACT_SEND, CMD_WREN);
                  q_job.steps[1] = mk_step(ACT_REL, 8'h00);
                  q_job.steps[2] = mk_step(ACT_SEND, CMD_PROG);
                  q_job.steps[3] = mk_step(ACT_SEND, req_a24[23:16]);
                  q_job.steps[4] = mk_step(ACT_SEND, req_a24[15:8]);
                  q_job.steps[5] = mk_step(ACT_SEND, req_a24[7:0]);
                  q_job.count    = COUNT_BITS'(6);
                  phase_in = PH_WDATA;
                  pend_in  = PEND_WRITE;
               end
            end
         end
         OP_WRITE_DATA: begin
            if (phase_ff == PH_WDATA) begin
               addr_in   = addr_inc;
               remain_in = remain_dec;
               q_job.steps[0] = mk_step(ACT_SEND, req_payload.data);
               if (chunk_end) begin
                  q_job.steps[1] = mk_step(ACT_REL, 8'h00);
                  q_job.steps[2] = mk_step(ACT_SEND, CMD_RDSR);
                  q_job.steps[3] = mk_step(ACT_RECV, 8'h00);
                  q_job.count    = COUNT_BITS'(4);
                  phase_in = PH_POLL;
               end else begin
                  q_job.count = COUNT_BITS'(1);
               end
            end
         end
         OP_SPI_RX: begin
            if (phase_ff == PH_READ) begin
               addr_in   = addr_inc;
               remain_in = remain_dec;
               q_job.steps[0] = mk_step(ACT_DATA, req_payload.data);
               if (remain_dec != '0) begin
                  q_job.steps[1] = mk_step(ACT_RECV, 8'h00);
                  q_job.count    = COUNT_BITS'(2);
               end else begin
                  q_job.steps[1] = mk_step(ACT_REL, 8'h00);
                  q_job.steps[2] = mk_step(ACT_DONE, 8'h00);
                  q_job.count    = COUNT_BITS'(3);
                  phase_in = PH_IDLE;
                  pend_in  = PEND_NONE;
               end
            end else if (phase_ff == PH_POLL) begin
               q_job.steps[0] = mk_step(ACT_REL, 8'h00);
               if (req_payload.data[0]) begin
                  // flash still busy: poll status again
                  q_job.steps[1] = mk_step(ACT_SEND, CMD_RDSR);
                  q_job.steps[2] = mk_step(ACT_RECV, 8'h00);
                  q_job.count    = COUNT_BITS'(3);
               end else if (pend_ff == PEND_WRITE && remain_ff != '0) begin
                  // next page chunk
                  q_job.steps[1] = mk_step(ACT_SEND, CMD_WREN);
                  q_job.steps[2] = mk_step(ACT_REL, 8'h00);
                  q_job.steps[3] = mk_step(ACT_SEND, CMD_PROG);
                  q_job.steps[4] = mk_step(ACT_SEND, cur_a24[23:16]);
                  q_job.steps[5] = mk_step(ACT_SEND, cur_a24[15:8]);
                  q_job.steps[6] = mk_step(ACT_SEND, cur_a24[7:0]);
                  q_job.count    = COUNT_BITS'(7);
                  phase_in = PH_WDATA;
               end else begin
                  q_job.steps[1] = mk_step(ACT_DONE, 8'h00);
                  q_job.count    = COUNT_BITS'(2);
                  phase_in = PH_IDLE;
                  pend_in  = PEND_NONE;
               end
            end
         end
         default: begin
            // unknown opcode: keep the reject list
         end
      endcase
   end

   // Advance operation state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         pend_ff   <= PEND_NONE;
         addr_ff   <= '0;
         remain_ff <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         pend_ff   <= pend_in;
         addr_ff   <= addr_in;
         remain_ff <= remain_in;
      end
   end

endmodule

@@ hdl/snfc_queue.sv @@
// ----------------------------------------------------------------------------
// snfc_queue
// Short job queue that lets the front and back stall independently.
// ----------------------------------------------------------------------------
module snfc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  snfc_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output snfc_pkg::job_type head_job
);
   import snfc_pkg::*;

   job_type               entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;

   assign full       = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ hdl/snfc_back.sv @@
// ----------------------------------------------------------------------------
// snfc_back
// Walks the action list at the queue head and sends one result item per
// cycle through a registered output stage while the output is not stalled.
// ----------------------------------------------------------------------------
module snfc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  snfc_pkg::job_type head_job,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output snfc_pkg::rsp_type rsp_payload
);
   import snfc_pkg::*;

   logic [STEP_BITS-1:0] idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic     load;
   logic     is_last;
   step_type step;

   assign load    = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign step    = head_job.steps[idx_ff];
   assign is_last = (COUNT_BITS'(idx_ff) == COUNT_BITS'(head_job.count - 1'b1));
   assign pop     = load && is_last;

   // Pick the next action and step the index
   always_comb begin
      idx_in            = idx_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_in            = rsp_ff;
      if (load) begin
         rsp_valid_in      = 1'b1;
         rsp_in.action     = step.action;
         rsp_in.byte_value = step.byte_value;
         rsp_in.last       = is_last;
         idx_in            = is_last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the result payload
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ hdl/spi_nor_flash_command_sequencer.sv @@
// ----------------------------------------------------------------------------
// spi_nor_flash_command_sequencer
// Host-side SPI NOR sequencer: turns requests and received SPI bytes into
// an ordered stream of SPI actions (read, sector erase, paged write, polling).
// ----------------------------------------------------------------------------
// An accepted item is stored in the job queue; its results leave through the
//   registered output stage. Throughput: one result per cycle from the
//   back end while the output is not stalled; an item yields 1 to 9 results,
//   and items are taken every cycle while the two-entry job queue has room.
// Reset: synchronous; phase idle, address and count zero, queue and output empty.
// ----------------------------------------------------------------------------
module spi_nor_flash_command_sequencer #(
   parameter int PAGE_BYTES   = snfc_pkg::DEF_PAGE_BYTES,
   parameter int ADDRESS_BITS = snfc_pkg::DEF_ADDRESS_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  snfc_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output snfc_pkg::rsp_type rsp_payload
);
   import snfc_pkg::*;

   logic    q_full;
   logic    q_push;
   job_type q_job;
   logic    q_pop;
   logic    head_valid;
   job_type head_job;

   snfc_front #(
      .PAGE_BYTES   (PAGE_BYTES),
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_job       (q_job)
   );

   snfc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_job),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   snfc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_job    (head_job),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // Output stage comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // Reject and done always close an item's result list
   a_close_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.action == ACT_REJ || rsp_payload.action == ACT_DONE)
      |-> rsp_payload.last)
      else $error("reject or done without last");

   // Control-only actions carry a zero byte
   a_zero_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.action == ACT_REL || rsp_payload.action == ACT_RECV ||
                    rsp_payload.action == ACT_DONE || rsp_payload.action == ACT_REJ)
      |-> rsp_payload.byte_value == 8'h00)
      else $error("nonzero byte on control action");

   // Queue never drains a job without a result going out
   a_pop_loads: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_valid && rsp_payload.last)
      else $error("queue pop without final result");

endmodule
